### src/clns_pkg.sv
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types and constants for the 4-bit character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  // request modes
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_INIT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_STROBE_HOLD = 2'd0;
  localparam logic [1:0] REG_INIT_HOLD   = 2'd1;
  localparam logic [1:0] REG_POWER_WAIT  = 2'd2;

  localparam logic [7:0] STROBE_HOLD_RST = 8'd3;
  localparam logic [7:0] INIT_HOLD_RST   = 8'd10;
  localparam logic [7:0] POWER_WAIT_RST  = 8'd40;

  // step of one nibble strobe
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_RISE  = 2'd1;
  localparam logic [1:0] PH_FALL  = 2'd2;

  localparam logic [2:0] WAKE_LAST_IDX = 3'd3;
  localparam logic [2:0] CMD_LAST_IDX  = 3'd5;
  localparam logic [3:0] WAKE_NIB      = 4'h3;
  localparam logic [3:0] WAKE_LAST_NIB = 4'h2;

  typedef enum logic [1:0] {
    KIND_WAIT,
    KIND_WAKE,
    KIND_BYTE
  } kind_e;

  typedef struct packed {
    logic       capture;
    logic       load;
    kind_e      kind;
    logic       init;
    logic [1:0] phase;
    logic       half;
    logic [2:0] idx;
    logic       last;
  } cmd_t;

  // command bytes sent at the end of power-up
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'b0010_1000;
      3'd1:    b = 8'b0000_1000;
      3'd2:    b = 8'b0000_0001;
      3'd3:    b = 8'b0000_0110;
      3'd4:    b = 8'b0000_1111;
      3'd5:    b = 8'b0000_0010;
      default: b = 8'b0000_0000;
    endcase
    return b;
  endfunction

endpackage

### src/clns_ctrl.sv
// ----------------------------------------------------------------------------
// clns_ctrl
// Sequencer state machine: walks the pin writes of one request.
// ----------------------------------------------------------------------------
module clns_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_mode_i,
  output logic          in_stall_o,
  input  logic          can_load_i,
  output clns_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_WAKE,
    S_BYTE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       half_q, half_d;
  logic [2:0] idx_q, idx_d;
  logic       init_q, init_d;
  logic       accept;
  logic       step;
  logic       byte_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign step       = (state_q != S_IDLE) && can_load_i;
  assign byte_done  = (phase_q == clns_pkg::PH_FALL) && half_q &&
                      (!init_q || (idx_q == clns_pkg::CMD_LAST_IDX));

  always_comb begin
    cmd_o.capture = accept;
    cmd_o.load    = step;
    cmd_o.init    = init_q;
    cmd_o.phase   = phase_q;
    cmd_o.half    = half_q;
    cmd_o.idx     = idx_q;
    cmd_o.last    = (state_q == S_BYTE) && byte_done;
    unique case (state_q)
      S_WAIT:  cmd_o.kind = clns_pkg::KIND_WAIT;
      S_WAKE:  cmd_o.kind = clns_pkg::KIND_WAKE;
      default: cmd_o.kind = clns_pkg::KIND_BYTE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    half_d  = half_q;
    idx_d   = idx_q;
    init_d  = init_q;
    unique case (state_q)
      S_IDLE: begin
        phase_d = clns_pkg::PH_SETUP;
        half_d  = 1'b0;
        idx_d   = '0;
        if (accept) begin
          unique case (in_mode_i) inside
            clns_pkg::MODE_CMD, clns_pkg::MODE_DATA: begin
              state_d = S_BYTE;
              init_d  = 1'b0;
            end
            clns_pkg::MODE_INIT: begin
              state_d = S_WAIT;
              init_d  = 1'b1;
            end
            default: state_d = S_IDLE;  // unused mode, no writes
          endcase
        end
      end
      S_WAIT: begin
        if (step) begin
          state_d = S_WAKE;
        end
      end
      S_WAKE: begin
        if (step) begin
          if (phase_q != clns_pkg::PH_FALL) begin
            phase_d = phase_q + 2'd1;
          end else begin
            phase_d = clns_pkg::PH_SETUP;
            if (idx_q == clns_pkg::WAKE_LAST_IDX) begin
              state_d = S_BYTE;
              idx_d   = '0;
            end else begin
              idx_d = idx_q + 3'd1;
            end
          end
        end
      end
      default: begin
        if (step) begin
          if (phase_q != clns_pkg::PH_FALL) begin
            phase_d = phase_q + 2'd1;
          end else begin
            phase_d = clns_pkg::PH_SETUP;
            half_d  = !half_q;
            if (byte_done) begin
              state_d = S_IDLE;
            end else if (half_q) begin
              idx_d = idx_q + 3'd1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= clns_pkg::PH_SETUP;
      half_q  <= 1'b0;
      idx_q   <= '0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      half_q  <= half_d;
      idx_q   <= idx_d;
      init_q  <= init_d;
    end
  end

`ifndef SYNTH
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q != S_IDLE))
    else $error("write loaded while idle");

  a_last_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("request did not end after its last write");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == clns_pkg::PH_SETUP) || (phase_q == clns_pkg::PH_RISE) ||
    (phase_q == clns_pkg::PH_FALL))
    else $error("strobe step out of range");

  a_unused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_mode_i != clns_pkg::MODE_CMD) && (in_mode_i != clns_pkg::MODE_DATA) &&
     (in_mode_i != clns_pkg::MODE_INIT)) |=> (state_q == S_IDLE))
    else $error("unused mode started a sequence");
`endif

endmodule

### src/clns_dp.sv
// ----------------------------------------------------------------------------
// clns_dp
// Datapath: configuration registers, request latch and output write register.
// ----------------------------------------------------------------------------
module clns_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  input  logic [1:0]     in_mode_i,
  input  logic [7:0]     in_byte_value_i,
  input  clns_pkg::cmd_t cmd_i,
  output logic           can_load_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [3:0]     out_nibble_o,
  output logic           out_reg_select_o,
  output logic           out_enable_o,
  output logic [7:0]     out_hold_ticks_o,
  output logic           out_last_o
);

  logic [7:0] strobe_hold_q, init_hold_q, power_wait_q;
  logic [7:0] byte_q;
  logic       rs_q;
  logic       out_valid_q, out_valid_d;
  logic [3:0] nibble_q, nibble_d;
  logic       rs_out_q, rs_out_d;
  logic       en_q, en_d;
  logic [7:0] hold_q, hold_d;
  logic       last_q;
  logic [7:0] cur_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_hold_q <= clns_pkg::STROBE_HOLD_RST;
      init_hold_q   <= clns_pkg::INIT_HOLD_RST;
      power_wait_q  <= clns_pkg::POWER_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        clns_pkg::REG_STROBE_HOLD: strobe_hold_q <= cfg_data_i;
        clns_pkg::REG_INIT_HOLD:   init_hold_q   <= cfg_data_i;
        clns_pkg::REG_POWER_WAIT:  power_wait_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latch the request on its transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= in_byte_value_i;
      rs_q   <= (in_mode_i == clns_pkg::MODE_DATA);
    end
  end

  assign cur_byte = cmd_i.init ? clns_pkg::init_cmd(cmd_i.idx) : byte_q;

  always_comb begin
    nibble_d = '0;
    rs_out_d = 1'b0;
    en_d     = (cmd_i.phase == clns_pkg::PH_RISE);
    hold_d   = '0;
    case (cmd_i.kind)
      clns_pkg::KIND_WAIT: begin
        en_d   = 1'b0;
        hold_d = power_wait_q;
      end
      clns_pkg::KIND_WAKE: begin
        nibble_d = (cmd_i.idx == clns_pkg::WAKE_LAST_IDX) ? clns_pkg::WAKE_LAST_NIB
                                                          : clns_pkg::WAKE_NIB;
        // the final wake pulse also holds after enable falls
        if (cmd_i.phase != clns_pkg::PH_FALL ||
            cmd_i.idx == clns_pkg::WAKE_LAST_IDX) begin
          hold_d = init_hold_q;
        end
      end
      default: begin
        nibble_d = cmd_i.half ? cur_byte[3:0] : cur_byte[7:4];
        rs_out_d = cmd_i.init ? 1'b0 : rs_q;
        if (cmd_i.phase != clns_pkg::PH_FALL) begin
          hold_d = strobe_hold_q;
        end
      end
    endcase
  end

  assign can_load_o  = !out_valid_q || !out_stall_i;
  assign out_valid_d = cmd_i.load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nibble_q <= nibble_d;
      rs_out_q <= rs_out_d;
      en_q     <= en_d;
      hold_q   <= hold_d;
      last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_nibble_o     = nibble_q;
  assign out_reg_select_o = rs_out_q;
  assign out_enable_o     = en_q;
  assign out_hold_ticks_o = hold_q;
  assign out_last_o       = last_q;

endmodule

### src/char_lcd_nibble_sequencer_unit.sv
// the first pin write is loaded into the output register after the request is registered in the state machine
// throughput: one pin write per cycle while the output is not stalled
// a byte request loads 6 pin writes and a power-up request 49, walked by the state machine
// the next request is taken the cycle after the last write is loaded
// reset: registers return to strobe_hold 3, init_hold 10, power_wait 40; idle
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_unit
// Turns command, data and power-up requests into 4-bit LCD pin writes.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_mode_i,
  input  logic [7:0] in_byte_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] out_nibble_o,
  output logic       out_reg_select_o,
  output logic       out_enable_o,
  output logic [7:0] out_hold_ticks_o,
  output logic       out_last_o
);

  clns_pkg::cmd_t cmd;
  logic           can_load;

  clns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_mode_i),
    .in_stall_o (in_stall_o),
    .can_load_i (can_load),
    .cmd_o      (cmd)
  );

  clns_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_mode_i        (in_mode_i),
    .in_byte_value_i  (in_byte_value_i),
    .cmd_i            (cmd),
    .can_load_o       (can_load),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_nibble_o     (out_nibble_o),
    .out_reg_select_o (out_reg_select_o),
    .out_enable_o     (out_enable_o),
    .out_hold_ticks_o (out_hold_ticks_o),
    .out_last_o       (out_last_o)
  );

endmodule
